@@ rtl/clr_pkg.sv @@
// Shared types and constants for the clamped linear remap unit.
package clr_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;
   localparam int DIV_STAGES = DATA_WIDTH;

   localparam int REQ_DATA_WIDTH = 5 * DATA_WIDTH;
   localparam int RSP_DATA_WIDTH = DATA_WIDTH;

   typedef logic signed [DATA_WIDTH-1:0] sword_type;
   typedef logic [DATA_WIDTH-1:0]        uword_type;
   typedef logic [PROD_WIDTH-1:0]        prod_type;

   // Values that ride along with the divider and finish the result
   typedef struct packed {
      sword_type out_min;
      logic      negate;
      logic      empty;
   } clr_side_type;

endpackage

@@ rtl/clr_divider.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
module clr_divider
   import clr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  prod_type     in_prod,
   input  uword_type    in_width,
   input  clr_side_type in_side,
   output logic         out_valid,
   output uword_type    out_quot,
   output clr_side_type out_side
);

   logic         valid_ff [DIV_STAGES];
   uword_type    rem_ff   [DIV_STAGES];
   uword_type    lo_ff    [DIV_STAGES];
   uword_type    width_ff [DIV_STAGES];
   clr_side_type side_ff  [DIV_STAGES];

   uword_type    rem_in   [DIV_STAGES];
   uword_type    lo_in    [DIV_STAGES];

   genvar g;
   generate
      for (g = 0; g < DIV_STAGES; g++) begin : g_step
         logic                valid_src;
         uword_type           rem_src;
         uword_type           lo_src;
         uword_type           width_src;
         clr_side_type        side_src;
         logic [DATA_WIDTH:0] trial;
         logic                take;

         // Pick the stage source: the product for the first step, the previous stage after
         if (g == 0) begin : g_first
            assign valid_src = in_valid;
            assign rem_src   = in_prod[PROD_WIDTH-1:DATA_WIDTH];
            assign lo_src    = in_prod[DATA_WIDTH-1:0];
            assign width_src = in_width;
            assign side_src  = in_side;
         end else begin : g_next
            assign valid_src = valid_ff[g-1];
            assign rem_src   = rem_ff[g-1];
            assign lo_src    = lo_ff[g-1];
            assign width_src = width_ff[g-1];
            assign side_src  = side_ff[g-1];
         end

         // Shift in the next dividend bit, subtract the divisor when it fits
         assign trial     = {rem_src, lo_src[DATA_WIDTH-1]};
         assign take      = (trial >= {1'b0, width_src});
         assign rem_in[g] = take ? DATA_WIDTH'(trial - {1'b0, width_src})
                                 : trial[DATA_WIDTH-1:0];
         assign lo_in[g]  = {lo_src[DATA_WIDTH-2:0], take};

         // Advance the valid bit
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[g] <= 1'b0;
            end else if (en) begin
               valid_ff[g] <= valid_src;
            end
         end

         // Advance the payload
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[g]   <= rem_in[g];
               lo_ff[g]    <= lo_in[g];
               width_ff[g] <= width_src;
               side_ff[g]  <= side_src;
            end
         end
      end
   endgenerate

   // The low word has turned into the quotient after the last step
   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_quot  = lo_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule

@@ rtl/clamped_linear_remap_unit.sv @@
// Top level of the clamped linear remap unit.
// Use: each request transaction carries two range bounds in either order, the
// output values paired with them and a sample, all signed Q16.16. The sample
// is clamped into the range and mapped linearly onto the output endpoints;
// the quotient is truncated toward zero. A zero-width range gives the
// out_at_high endpoint (bound_b's) and raises the range_empty flag on rsp_tuser.
// Channels: req_* takes one transaction per cycle while not stalled, rsp_*
// returns exactly one response per request, in order.
// Pipeline: swap, clamp, multiply, 32 divider stages, final add, from request
// acceptance to rsp_tvalid. Throughput: one item per cycle while not stalled,
// set by the fully pipelined divider that yields one quotient bit per stage.
// Reset: synchronous, clears all valid bits; no transaction is held.
// Stall: when rsp_tready is low, the waiting response drops into a one-entry
// skid register; the pipeline then holds and req_tready falls until the skid
// register is taken. Nothing is lost or repeated.
module clamped_linear_remap_unit
   import clr_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // out_at_low, out_at_high, bound_a, bound_b, sample_in (32 bits each)
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // mapped_out
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // range_empty
   output logic                      rsp_tuser
);

   logic en;

   sword_type in_out_low;
   sword_type in_out_high;
   sword_type in_bound_a;
   sword_type in_bound_b;
   sword_type in_sample;
   logic      in_swap;

   logic      s1_valid_ff;
   sword_type s1_rmin_ff;
   sword_type s1_rmax_ff;
   sword_type s1_omin_ff;
   sword_type s1_omax_ff;
   sword_type s1_sample_ff;

   sword_type s2_clamped;
   logic      s2_valid_ff;
   uword_type s2_num_ff;
   uword_type s2_width_ff;
   uword_type s2_mag_ff;
   logic      s2_neg_ff;
   sword_type s2_omin_ff;

   logic         s3_valid_ff;
   prod_type     s3_prod_ff;
   uword_type    s3_width_ff;
   clr_side_type s3_side_ff;
   clr_side_type s3_side_in;

   logic         div_valid;
   uword_type    div_quot;
   clr_side_type div_side;

   logic      fin_valid_ff;
   sword_type fin_result_ff;
   sword_type fin_result_in;
   logic      fin_empty_ff;

   logic      skid_valid_ff;
   sword_type skid_result_ff;
   logic      skid_empty_ff;

   // Hold the whole pipeline while the skid register is occupied
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // Unpack the request fields
   assign in_out_low  = req_tdata[DATA_WIDTH-1:0];
   assign in_out_high = req_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
   assign in_bound_a  = req_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH];
   assign in_bound_b  = req_tdata[4*DATA_WIDTH-1:3*DATA_WIDTH];
   assign in_sample   = req_tdata[5*DATA_WIDTH-1:4*DATA_WIDTH];
   assign in_swap     = (in_bound_a >= in_bound_b);

   // Stage 1: order the bounds and swap the paired endpoints with them
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_rmin_ff   <= in_swap ? in_bound_b : in_bound_a;
         s1_rmax_ff   <= in_swap ? in_bound_a : in_bound_b;
         s1_omin_ff   <= in_swap ? in_out_high : in_out_low;
         s1_omax_ff   <= in_swap ? in_out_low : in_out_high;
         s1_sample_ff <= in_sample;
      end
   end

   // Stage 2: clamp, then take offset, range width and endpoint span
   always_comb begin
      if (s1_sample_ff < s1_rmin_ff) begin
         s2_clamped = s1_rmin_ff;
      end else if (s1_sample_ff >= s1_rmax_ff) begin
         s2_clamped = s1_rmax_ff;
      end else begin
         s2_clamped = s1_sample_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_num_ff   <= uword_type'(s2_clamped - s1_rmin_ff);
         s2_width_ff <= uword_type'(s1_rmax_ff - s1_rmin_ff);
         s2_neg_ff   <= (s1_omax_ff < s1_omin_ff);
         s2_mag_ff   <= (s1_omax_ff < s1_omin_ff) ? uword_type'(s1_omin_ff - s1_omax_ff)
                                                  : uword_type'(s1_omax_ff - s1_omin_ff);
         s2_omin_ff  <= s1_omin_ff;
      end
   end

   // Stage 3: exact product of offset and span magnitude
   always_comb begin
      s3_side_in.out_min = s2_omin_ff;
      s3_side_in.negate  = s2_neg_ff;
      s3_side_in.empty   = (s2_width_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_prod_ff  <= PROD_WIDTH'(s2_num_ff) * PROD_WIDTH'(s2_mag_ff);
         s3_width_ff <= s2_width_ff;
         s3_side_ff  <= s3_side_in;
      end
   end

   // Divide the product by the range width
   clr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_prod   (s3_prod_ff),
      .in_width  (s3_width_ff),
      .in_side   (s3_side_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_side  (div_side)
   );

   // Final stage: add or subtract the quotient from the low endpoint
   always_comb begin
      if (div_side.empty) begin
         fin_result_in = div_side.out_min;
      end else if (div_side.negate) begin
         fin_result_in = sword_type'(div_side.out_min - div_quot);
      end else begin
         fin_result_in = sword_type'(div_side.out_min + div_quot);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_result_ff <= fin_result_in;
         fin_empty_ff  <= div_side.empty;
      end
   end

   // Park a stalled response in the skid register, release it when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         skid_valid_ff <= !rsp_tready;
      end else begin
         skid_valid_ff <= fin_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_result_ff <= fin_result_ff;
         skid_empty_ff  <= fin_empty_ff;
      end
   end

   // Drive the response from the skid register first
   assign rsp_tvalid = skid_valid_ff || fin_valid_ff;
   assign rsp_tdata  = skid_valid_ff ? skid_result_ff : fin_result_ff;
   assign rsp_tuser  = skid_valid_ff ? skid_empty_ff : fin_empty_ff;

`ifndef NO_ASSERTIONS
   // The skid register fills only from a stalled final stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(fin_valid_ff && !rsp_tready))
      else $error("skid register filled without a stalled response");

   // A parked response stays put until it is taken
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_tready |=> skid_valid_ff && $stable(skid_result_ff)
         && $stable(skid_empty_ff))
      else $error("parked response changed before it was taken");

   // A zero-width range clamps the offset to zero, so the product is zero
   assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && s3_side_ff.empty |-> s3_prod_ff == '0)
      else $error("nonzero product for an empty range");
`endif

endmodule
